// ===== rtl/core/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// shared types and constants of the polyphonic voice allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int VOICE_W = 4;
    localparam int ACT_W   = 3;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_RETRIGGER = 3'd0,
        ACT_FREE      = 3'd1,
        ACT_STEAL     = 3'd2,
        ACT_RELEASE   = 3'd3,
        ACT_UNMATCHED = 3'd4
    } action_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pva_event_if.sv =====
// ----------------------------------------------------------------------------
// pva_event_if
// note event channel: note number and velocity with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_event_if;
    logic                       valid;
    logic                       ready;
    logic [pva_pkg::NOTE_W-1:0] note;
    logic [pva_pkg::VEL_W-1:0]  velocity;

    modport source (output valid, output note, output velocity, input ready);
    modport sink   (input valid, input note, input velocity, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pva_result_if.sv =====
// ----------------------------------------------------------------------------
// pva_result_if
// allocation result channel with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_result_if;
    logic                        valid;
    logic                        ready;
    logic [pva_pkg::VOICE_W-1:0] voice;
    logic [pva_pkg::ACT_W-1:0]   action;
    logic [pva_pkg::NOTE_W-1:0]  note_out;
    logic [pva_pkg::VEL_W-1:0]   velocity_out;
    logic [pva_pkg::COUNT_W-1:0] active_count;

    modport source (output valid, output voice, output action, output note_out,
                    output velocity_out, output active_count, input ready);
    modport sink   (input valid, input voice, input action, input note_out,
                    input velocity_out, input active_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pva_ctrl.sv =====
// ----------------------------------------------------------------------------
// pva_ctrl
// sequencer: accept a request, scan the voices, commit the allocation
// ----------------------------------------------------------------------------
`default_nettype none

module pva_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pva_pkg::status_t status,
    output pva_pkg::cmd_t         cmd
);

    pva_pkg::state_t state_reg;
    pva_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pva_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pva_pkg::ST_SCAN;
                end
            end
            pva_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = pva_pkg::ST_COMMIT;
                end
            end
            pva_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pva_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            pva_pkg::ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/pva_datapath.sv =====
// ----------------------------------------------------------------------------
// pva_datapath
// voice table, round-robin pointer, one-voice-per-cycle scan, result register
// ----------------------------------------------------------------------------
`default_nettype none

module pva_datapath #(
    parameter int NUM_VOICES = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pva_pkg::cmd_t               cmd,
    output pva_pkg::status_t                 status,
    input  wire logic [pva_pkg::NOTE_W-1:0]  in_note,
    input  wire logic [pva_pkg::VEL_W-1:0]   in_velocity,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pva_pkg::VOICE_W-1:0]      out_voice,
    output logic [pva_pkg::ACT_W-1:0]        out_action,
    output logic [pva_pkg::NOTE_W-1:0]       out_note,
    output logic [pva_pkg::VEL_W-1:0]        out_velocity,
    output logic [pva_pkg::COUNT_W-1:0]      out_count
);

    localparam int IDX_W = $clog2(NUM_VOICES);
    localparam int CNT_W = $clog2(NUM_VOICES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);
    localparam logic [IDX_W:0]   NV_EXT   = (IDX_W + 1)'(NUM_VOICES);

    // voice table
    logic [pva_pkg::NOTE_W-1:0] note_reg [NUM_VOICES];
    logic [NUM_VOICES-1:0]      gate_reg;
    logic [IDX_W-1:0]           ptr_reg;
    logic [IDX_W-1:0]           ptr_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    // captured request
    logic [pva_pkg::NOTE_W-1:0] item_note_reg;
    logic [pva_pkg::VEL_W-1:0]  item_vel_reg;

    // scan trackers
    logic [IDX_W-1:0] scan_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             hi_found_reg;
    logic [IDX_W-1:0] hi_idx_reg;
    logic             lo_found_reg;
    logic [IDX_W-1:0] lo_idx_reg;

    // result register
    logic                        out_valid_reg;
    logic [pva_pkg::VOICE_W-1:0] out_voice_reg;
    pva_pkg::action_t            out_action_reg;
    logic [pva_pkg::NOTE_W-1:0]  out_note_reg;
    logic [pva_pkg::VEL_W-1:0]   out_vel_reg;
    logic [pva_pkg::COUNT_W-1:0] out_count_reg;

    logic             cur_hit;
    logic             cur_free;
    logic             is_release;
    pva_pkg::action_t act;
    logic [IDX_W-1:0] tgt;
    logic [IDX_W:0]   tgt_inc;

    assign cur_hit  = gate_reg[scan_reg] && (note_reg[scan_reg] == item_note_reg);
    assign cur_free = !gate_reg[scan_reg];

    assign status.scan_last = (scan_reg == LAST_IDX);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign is_release = (item_vel_reg == '0);

    always_comb
    begin
        act = pva_pkg::ACT_STEAL;
        tgt = ptr_reg;
        if (is_release)
        begin
            if (hit_found_reg)
            begin
                act = pva_pkg::ACT_RELEASE;
                tgt = hit_idx_reg;
            end
            else
            begin
                act = pva_pkg::ACT_UNMATCHED;
            end
        end
        else if (hit_found_reg)
        begin
            act = pva_pkg::ACT_RETRIGGER;
            tgt = hit_idx_reg;
        end
        else if (hi_found_reg)
        begin
            act = pva_pkg::ACT_FREE;
            tgt = hi_idx_reg;
        end
        else if (lo_found_reg)
        begin
            act = pva_pkg::ACT_FREE;
            tgt = lo_idx_reg;
        end
    end

    assign tgt_inc = {1'b0, tgt} + 1'b1;

    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        case (act)
            pva_pkg::ACT_FREE:
            begin
                ptr_next   = (tgt_inc == NV_EXT) ? '0 : tgt_inc[IDX_W-1:0];
                count_next = count_reg + 1'b1;
            end
            pva_pkg::ACT_STEAL:
            begin
                ptr_next = (tgt_inc == NV_EXT) ? '0 : tgt_inc[IDX_W-1:0];
            end
            pva_pkg::ACT_RELEASE:
            begin
                count_next = count_reg - 1'b1;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg      <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                ptr_reg   <= ptr_next;
                count_reg <= count_next;
                if (act == pva_pkg::ACT_RELEASE)
                begin
                    gate_reg[tgt] <= 1'b0;
                end
                else if (act != pva_pkg::ACT_UNMATCHED)
                begin
                    gate_reg[tgt] <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan index and found flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '0;
            hit_found_reg <= 1'b0;
            hi_found_reg  <= 1'b0;
            lo_found_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            scan_reg      <= '0;
            hit_found_reg <= 1'b0;
            hi_found_reg  <= 1'b0;
            lo_found_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (!status.scan_last)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (!hit_found_reg && cur_hit)
            begin
                hit_found_reg <= 1'b1;
            end
            if (!hi_found_reg && cur_free && (scan_reg >= ptr_reg))
            begin
                hi_found_reg <= 1'b1;
            end
            if (!lo_found_reg && cur_free)
            begin
                lo_found_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_note_reg <= in_note;
            item_vel_reg  <= in_velocity;
        end
        if (cmd.step)
        begin
            if (!hit_found_reg && cur_hit)
            begin
                hit_idx_reg <= scan_reg;
            end
            if (!hi_found_reg && cur_free && (scan_reg >= ptr_reg))
            begin
                hi_idx_reg <= scan_reg;
            end
            if (!lo_found_reg && cur_free)
            begin
                lo_idx_reg <= scan_reg;
            end
        end
        if (cmd.commit)
        begin
            if ((act != pva_pkg::ACT_RELEASE) && (act != pva_pkg::ACT_UNMATCHED))
            begin
                note_reg[tgt] <= item_note_reg;
            end
            out_action_reg <= act;
            out_vel_reg    <= item_vel_reg;
            out_count_reg  <= pva_pkg::COUNT_W'(count_next);
            if (act == pva_pkg::ACT_UNMATCHED)
            begin
                out_voice_reg <= '0;
                out_note_reg  <= '0;
            end
            else
            begin
                out_voice_reg <= pva_pkg::VOICE_W'(tgt);
                out_note_reg  <= item_note_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_voice    = out_voice_reg;
    assign out_action   = out_action_reg;
    assign out_note     = out_note_reg;
    assign out_velocity = out_vel_reg;
    assign out_count    = out_count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/poly_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// poly_voice_allocator
// round-robin voice allocation with stealing for note events
// one request at a time: the request is captured, the scan reads one voice of
//   the table per cycle, and the commit writes the table and the result register
//   once the previous result has been taken
// a new request is taken while the previous result waits in its register
// reset clears all gates, the round-robin pointer and the active count
// ----------------------------------------------------------------------------
`default_nettype none

module poly_voice_allocator #(
    parameter int NUM_VOICES = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pva_event_if.sink      evt,
    pva_result_if.source   res
);

    pva_pkg::cmd_t    cmd;
    pva_pkg::status_t status;
    logic             in_ready;

    pva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pva_datapath #(
        .NUM_VOICES (NUM_VOICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_note      (evt.note),
        .in_velocity  (evt.velocity),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .out_voice    (res.voice),
        .out_action   (res.action),
        .out_note     (res.note_out),
        .out_velocity (res.velocity_out),
        .out_count    (res.active_count)
    );

    assign evt.ready = in_ready;

endmodule

`default_nettype wire

// ===== rtl/core/pva_checker.sv =====
// ----------------------------------------------------------------------------
// pva_checker
// port-level checks of the voice allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pva_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        evt_valid,
    input wire logic                        evt_ready,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic [pva_pkg::VOICE_W-1:0] res_voice,
    input wire logic [pva_pkg::ACT_W-1:0]   res_action,
    input wire logic [pva_pkg::NOTE_W-1:0]  res_note,
    input wire logic [pva_pkg::VEL_W-1:0]   res_velocity,
    input wire logic [pva_pkg::COUNT_W-1:0] res_count
);

    // result holds while stalled
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_voice)
            && $stable(res_action) && $stable(res_count))
        else $error("result changed while stalled");

    // one request in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("request taken while busy");

    // unmatched release reports nothing
    a_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_action == pva_pkg::ACT_UNMATCHED)
            |-> (res_voice == '0) && (res_note == '0) && (res_velocity == '0))
        else $error("unmatched release carries data");

    // velocity agrees with the kind of action
    a_release_vel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_velocity == '0) == ((res_action == pva_pkg::ACT_RELEASE)
            || (res_action == pva_pkg::ACT_UNMATCHED))))
        else $error("action does not match velocity");

    // allocation leaves at least one voice gated
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res_action == pva_pkg::ACT_RETRIGGER)
            || (res_action == pva_pkg::ACT_FREE) || (res_action == pva_pkg::ACT_STEAL))
            |-> (res_count != '0))
        else $error("allocation with no active voice");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt_valid    (evt.valid),
    .evt_ready    (evt.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_voice    (res.voice),
    .res_action   (res.action),
    .res_note     (res.note_out),
    .res_velocity (res.velocity_out),
    .res_count    (res.active_count)
);

`default_nettype wire
